FILE: design/tfp_pkg.sv
`default_nettype none
package tfp_pkg;

   localparam int FRAME_BYTES = 64;
   localparam int STAMP_BYTES = 4;
   localparam int MAX_VALUE_BYTES = 8;
   localparam int RESET_TOLERANCE = 1000;
   localparam int QUEUE_DEPTH = 2;

   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int FILL_W = $clog2(FRAME_BYTES + 1);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0] tick_count;
      logic [31:0] stamp_word;
      logic [7:0]  sample_code;
      logic [63:0] value_word;
      logic [3:0]  value_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic              flush;
      logic              new_frame;
      logic [FILL_W-1:0] flush_len;
      logic [ADDR_W-1:0] wr_base;
      logic [31:0]       stamp_word;
      logic [7:0]        sample_code;
      logic [63:0]       value_word;
      logic [3:0]        nbytes;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_FLUSH,
      BACK_STAMP,
      BACK_CODE,
      BACK_VALUE
   } back_state_type;

endpackage
`default_nettype wire

FILE: design/telemetry_frame_packer.sv
// Telemetry frame packer: each accepted item appends a code byte and 1 to 8
// value bytes (most significant first) to a frame that starts with the
// 32-bit stamp word; when the tick count leaves the configured tolerance or
// the sample does not fit, the previous frame is first sent out one byte per
// item on the response channel, with frame_end set on its last byte. A front
// stage classifies each item combinationally and queues a command (two deep);
// the back stage, whose frame memory has a read and a write port, writes the
// four stamp bytes when it opens a new frame, then the code byte and n value
// bytes, and flushes one byte per cycle while the response side is ready.
`default_nettype none
module telemetry_frame_packer
   import tfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data
);

   cmd_push_type push;
   logic         push_ready;
   logic         pop_valid;
   logic         pop_ready;
   cmd_type      pop_cmd;

   tfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_ready  (push_ready)
   );

   tfp_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   tfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: design/tfp_front.sv
`default_nettype none
module tfp_front
   import tfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data,
   output cmd_push_type      push,
   input  wire logic         push_ready
);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       start_ff, start_in;
   logic [31:0]       tol_ff, tol_in;

   logic [3:0]        nb;
   logic [31:0]       diff;
   logic              late, full, empty, flush, new_frame;
   logic [FILL_W-1:0] room, need, base;
   logic              accept;

   always_comb begin
      if (req_data.value_bytes == 4'd0) begin
         nb = 4'd1;
      end else if (req_data.value_bytes > 4'(MAX_VALUE_BYTES)) begin
         nb = 4'(MAX_VALUE_BYTES);
      end else begin
         nb = req_data.value_bytes;
      end
      diff      = req_data.tick_count - start_ff;
      late      = diff > tol_ff;
      room      = FILL_W'(FRAME_BYTES) - fill_ff;
      need      = FILL_W'(nb) + FILL_W'(1);
      full      = room < need;
      empty     = fill_ff == '0;
      flush     = !empty && (late || full);
      new_frame = empty || flush;
      base      = new_frame ? FILL_W'(STAMP_BYTES) : fill_ff;

      req_ready = push_ready;
      accept    = req_valid && push_ready;

      push.valid               = req_valid;
      push.cmd.flush           = flush;
      push.cmd.new_frame       = new_frame;
      push.cmd.flush_len       = fill_ff;
      push.cmd.wr_base         = base[ADDR_W-1:0];
      push.cmd.stamp_word      = req_data.stamp_word;
      push.cmd.sample_code     = req_data.sample_code;
      push.cmd.value_word      = req_data.value_word;
      push.cmd.nbytes          = nb;

      fill_in  = fill_ff;
      start_in = start_ff;
      if (accept) begin
         fill_in = base + need;
         if (new_frame) begin
            start_in = req_data.tick_count;
         end
      end
      tol_in = csr_wr_en ? csr_wr_data : tol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         start_ff <= '0;
         tol_ff   <= 32'(RESET_TOLERANCE);
      end else begin
         fill_ff  <= fill_in;
         start_ff <= start_in;
         tol_ff   <= tol_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tfp_cmd_queue.sv
`default_nettype none
module tfp_cmd_queue
   import tfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_push_type  push,
   output logic               push_ready,
   output logic               pop_valid,
   output cmd_type            pop_cmd,
   input  wire logic          pop_ready
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_cmd    = entry_ff[rd_ptr_ff];
      do_push    = push.valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tfp_back.sv
`default_nettype none
module tfp_back
   import tfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     pop_valid,
   input  wire cmd_type  pop_cmd,
   output logic          pop_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;

   logic [7:0]        frame_mem [FRAME_BYTES];
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              advance, can_read, last_read;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd;
   logic [FILL_W-1:0] last_idx;

   always_comb begin
      advance   = !rsp_valid_ff || rsp_ready;
      can_read  = !rd_valid_ff || advance;
      last_idx  = cmd_ff.flush_len - FILL_W'(1);
      last_read = {1'b0, idx_ff} == last_idx;

      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      wp_in       = wp_ff;
      pop_ready   = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_wa      = wp_ff;
      mem_ra      = idx_ff;
      mem_wd      = cmd_ff.sample_code;
      rd_last_in  = rd_last_ff;
      rd_valid_in = rd_valid_ff && !advance;

      case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in = pop_cmd;
               idx_in = '0;
               wp_in  = pop_cmd.wr_base;
               if (pop_cmd.flush) begin
                  state_in = BACK_FLUSH;
               end else if (pop_cmd.new_frame) begin
                  state_in = BACK_STAMP;
               end else begin
                  state_in = BACK_CODE;
               end
            end
         end
         BACK_FLUSH: begin
            if (can_read) begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               rd_last_in  = last_read;
               idx_in      = idx_ff + 1'b1;
               if (last_read) begin
                  idx_in   = '0;
                  state_in = BACK_STAMP;
               end
            end
         end
         BACK_STAMP: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = cmd_ff.stamp_word[{~idx_ff[1:0], 3'b000} +: 8];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == ADDR_W'(STAMP_BYTES - 1)) begin
               state_in = BACK_CODE;
            end
         end
         BACK_CODE: begin
            mem_we   = 1'b1;
            wp_in    = wp_ff + 1'b1;
            idx_in   = ADDR_W'(cmd_ff.nbytes - 4'd1);
            state_in = BACK_VALUE;
         end
         BACK_VALUE: begin
            mem_we = 1'b1;
            mem_wd = cmd_ff.value_word[{idx_ff[2:0], 3'b000} +: 8];
            wp_in  = wp_ff + 1'b1;
            idx_in = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in        = rd_valid_ff;
         rsp_in.frame_byte   = rd_data_ff;
         rsp_in.frame_end    = rd_last_ff;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      wp_ff      <= wp_in;
      rd_last_ff <= rd_last_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/telemetry_frame_packer_tb.sv
`timescale 1ns / 1ps
module telemetry_frame_packer_tb;
   import tfp_pkg::*;

   localparam int SETTLE_CYCLES = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int samples_sent = 0;
   int bytes_checked = 0;
   int frames_checked = 0;

   logic [7:0]  frame_model [FRAME_BYTES];
   int unsigned fill_model = 0;
   logic [31:0] start_ticks_model = '0;
   logic [31:0] tolerance_model = RESET_TOLERANCE;
   rsp_type     pending_bytes [$];

   telemetry_frame_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Inputs only change at rising edges, so what is seen at the falling edge
   // is exactly what the next rising edge will capture.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("frame byte %h arrived with nothing expected",
                                      rsp_data.frame_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.frame_byte !== want.frame_byte)
               report_mismatch($sformatf("frame_byte got %h, expected %h",
                                         rsp_data.frame_byte, want.frame_byte));
            if (rsp_data.frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end got %b, expected %b on byte %h",
                                         rsp_data.frame_end, want.frame_end, want.frame_byte));
            bytes_checked++;
            if (want.frame_end) frames_checked++;
         end
      end
   end

   function automatic void predict_frame_bytes(input req_type s);
      int unsigned nbytes;
      logic [31:0] diff;
      logic        opening;
      rsp_type     b;
      nbytes = 32'(s.value_bytes);
      if (nbytes < 1) nbytes = 1;
      if (nbytes > MAX_VALUE_BYTES) nbytes = MAX_VALUE_BYTES;
      opening = (fill_model == 0);
      if (!opening) begin
         diff = s.tick_count - start_ticks_model;
         if (diff > tolerance_model || FRAME_BYTES - fill_model < 1 + nbytes) begin
            for (int i = 0; i < fill_model; i++) begin
               b.frame_byte = frame_model[ADDR_W'(i)];
               b.frame_end = (i + 1 == fill_model);
               pending_bytes.push_back(b);
            end
            opening = 1'b1;
         end
      end
      if (opening) begin
         for (int i = 0; i < STAMP_BYTES; i++)
            frame_model[ADDR_W'(i)] = s.stamp_word[31 - 8 * i -: 8];
         fill_model = STAMP_BYTES;
         start_ticks_model = s.tick_count;
      end
      frame_model[ADDR_W'(fill_model)] = s.sample_code;
      fill_model++;
      for (int i = nbytes; i > 0; i--) begin
         frame_model[ADDR_W'(fill_model)] = s.value_word[8 * i - 1 -: 8];
         fill_model++;
      end
   endfunction

   function automatic req_type make_sample(input logic [31:0] ticks, input logic [31:0] stamp,
                                           input logic [7:0] code, input logic [63:0] value,
                                           input logic [3:0] nbytes);
      req_type s;
      s.tick_count = ticks;
      s.stamp_word = stamp;
      s.sample_code = code;
      s.value_word = value;
      s.value_bytes = nbytes;
      return s;
   endfunction

   task automatic send_sample(input req_type s);
      logic took;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      predict_frame_bytes(s);
      samples_sent++;
   endtask

   task automatic wait_until_drained();
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [31:0] value);
      wait_until_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tolerance_model = value;
   endtask

   task automatic test_directed_frames();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_sample(make_sample(32'd100, 32'hDEAD_BEEF, 8'h00, 64'h0, 4'd1));
      send_sample(make_sample(32'd1100, 32'h0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
      send_sample(make_sample(32'd1101, 32'h0123_4567, 8'h5A, 64'h0123_4567_89AB_CDEF, 4'd0));
      send_sample(make_sample(32'd1101, $urandom, 8'hA5, {$urandom, $urandom}, 4'd9));
      send_sample(make_sample(32'd1101, $urandom, 8'h3C, {$urandom, $urandom}, 4'd15));
      repeat (4) send_sample(make_sample(32'd1101, $urandom, 8'($urandom_range(0, 255)),
                                         {$urandom, $urandom}, 4'd8));
      repeat (2) send_sample(make_sample(32'd1101, $urandom, 8'($urandom_range(0, 255)),
                                         {$urandom, $urandom}, 4'd1));
      send_sample(make_sample(32'd1101, 32'hFFFF_FFFF, 8'h81, 64'h0, 4'd1));
      send_sample(make_sample(32'hFFFF_FF80, $urandom, 8'h7E, {$urandom, $urandom}, 4'd2));
      send_sample(make_sample(32'h0000_0100, $urandom, 8'h11, {$urandom, $urandom}, 4'd3));
      send_sample(make_sample(32'hFFFF_FF7F, $urandom, 8'h22, {$urandom, $urandom}, 4'd4));
      req_valid <= 1'b0;
   endtask

   task automatic test_tolerance_extremes();
      csr_write(32'd0);
      send_sample(make_sample(32'd500, $urandom, 8'h01, {$urandom, $urandom}, 4'd5));
      send_sample(make_sample(32'd500, $urandom, 8'h02, {$urandom, $urandom}, 4'd6));
      send_sample(make_sample(32'd501, $urandom, 8'h03, {$urandom, $urandom}, 4'd7));
      send_sample(make_sample(32'd500, $urandom, 8'h04, {$urandom, $urandom}, 4'd8));
      req_valid <= 1'b0;
      csr_write(32'hFFFF_FFFF);
      send_sample(make_sample(32'd0, $urandom, 8'h05, {$urandom, $urandom}, 4'd8));
      send_sample(make_sample(32'hFFFF_FFFF, $urandom, 8'h06, {$urandom, $urandom}, 4'd8));
      repeat (6) send_sample(make_sample($urandom, $urandom, 8'($urandom_range(0, 255)),
                                         {$urandom, $urandom}, 4'd8));
      req_valid <= 1'b0;
   endtask

   task automatic test_random_traffic(input logic [31:0] tolerance, input int idle_pct,
                                      input int stall_pct, input int count);
      logic [31:0] cursor;
      logic [31:0] span;
      logic [3:0]  nbytes;
      int          pick;
      csr_write(tolerance);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      cursor = $urandom;
      span = (tolerance > 32'd2000) ? 32'd2000 : tolerance;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) cursor += $urandom_range(0, span / 4);
         else if (pick < 75) cursor += $urandom_range(0, span);
         else if (pick < 88) cursor += tolerance + 32'd1 + $urandom_range(0, 99);
         else cursor = $urandom;
         if ($urandom_range(0, 9) < 9) nbytes = 4'($urandom_range(1, MAX_VALUE_BYTES));
         else nbytes = 4'($urandom_range(0, 15));
         send_sample(make_sample(cursor, $urandom, 8'($urandom_range(0, 255)),
                                 {$urandom, $urandom}, nbytes));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_tolerance_extremes();
      test_random_traffic(RESET_TOLERANCE, 0, 0, 70);
      test_random_traffic(32'hFFFF_FFFF, 71, 0, 70);
      test_random_traffic(32'd0, 0, 71, 70);
      test_random_traffic($urandom_range(1, 5000), 30, 30, 70);
      wait_until_drained();
      $display("Sent %0d samples under tolerances of zero, the reset value, all ones and random.",
               samples_sent);
      $display("Checked %0d frame bytes in %0d frames across four idle and stall mixes.",
               bytes_checked, frames_checked);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d frame bytes still expected.", pending_bytes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
design/tfp_pkg.sv
design/tfp_front.sv
design/tfp_cmd_queue.sv
design/tfp_back.sv
design/telemetry_frame_packer.sv
tb/sv/telemetry_frame_packer_tb.sv
